### src/csrr_pkg.sv
// Shared types and constants of the channel sum / ReLU reducer.
// Holds field widths, register codes, the configuration and control structs.
// No dependencies.
package csrr_pkg;

  localparam int unsigned LANES_DEF         = 8;
  localparam int unsigned PLANE_VECTORS_DEF = 1024;
  localparam int unsigned MAX_CHANNELS_DEF  = 256;

  localparam int unsigned LANE_W     = 16;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned DEST_W     = 28;
  localparam int unsigned GEOM_W     = 11;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned CHAN_REG_W = 9;
  localparam int unsigned KPI_W      = 11;
  localparam int unsigned IMG_W      = 8;
  localparam int unsigned KIDX_W     = 10;
  localparam int unsigned CHAN_CMP_W = 13;
  localparam int unsigned LIN_W      = 20;
  localparam int unsigned RECIP_W    = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam int unsigned PIPE_DEPTH = 4;
  localparam int unsigned FIFO_DEPTH = 8;

  localparam logic [GEOM_W-1:0] GEOM_MAX = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT     = 3'd0,
    REG_VECTOR_COLS   = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_RELU_ENABLE   = 3'd3,
    REG_KERNELS       = 3'd4,
    REG_IMAGE_INDEX   = 3'd5,
    REG_KERNEL_INDEX  = 3'd6
  } csrr_reg_e;

  typedef struct packed {
    logic [GEOM_W-1:0]     row_count;
    logic [GEOM_W-1:0]     vector_columns;
    logic [CHAN_REG_W-1:0] channel_count;
    logic                  relu_enable;
    logic [KPI_W-1:0]      kernels_per_image;
    logic [IMG_W-1:0]      image_index;
    logic [KIDX_W-1:0]     kernel_index;
  } csrr_cfg_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic emit;
    logic plane_done;
    logic relu;
  } csrr_ctrl_t;

endpackage

### src/csrr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old data.
// No dependencies.
module csrr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/csrr_lane.sv
// One accumulator lane: plane memory bank, read-modify-write with forwarding, ReLU.
// Depends on csrr_pkg and csrr_ram.
module csrr_lane #(
  parameter int unsigned PLANE_VECTORS = csrr_pkg::PLANE_VECTORS_DEF,
  localparam int unsigned AW           = $clog2(PLANE_VECTORS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [csrr_pkg::LANE_W-1:0]  x_i,
  input  csrr_pkg::csrr_ctrl_t                ctrl3_i,
  input  logic [AW-1:0]                       addr3_i,
  output logic signed [csrr_pkg::SUM_W-1:0]   sum_o
);
  import csrr_pkg::*;

  logic signed [LANE_W-1:0] x_pipe_q [PIPE_DEPTH];
  logic                     valid4_q;
  logic                     first4_q;
  logic                     relu4_q;
  logic [AW-1:0]            addr4_q;
  logic                     fwd_valid_q;
  logic [AW-1:0]            fwd_addr_q;
  logic [SUM_W-1:0]         fwd_data_q;
  logic [SUM_W-1:0]         rdata;
  logic [SUM_W-1:0]         base;
  logic [SUM_W-1:0]         x_ext;
  logic [SUM_W-1:0]         acc;

  always_ff @(posedge clk_i) begin
    x_pipe_q[0] <= x_i;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      x_pipe_q[i] <= x_pipe_q[i-1];
    end
    first4_q   <= ctrl3_i.first;
    relu4_q    <= ctrl3_i.relu;
    addr4_q    <= addr3_i;
    fwd_addr_q <= addr4_q;
    fwd_data_q <= acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid4_q    <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      valid4_q    <= ctrl3_i.valid;
      fwd_valid_q <= valid4_q;
    end
  end

  csrr_ram #(
    .WIDTH (SUM_W),
    .DEPTH (PLANE_VECTORS)
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (valid4_q),
    .waddr_i (addr4_q),
    .wdata_i (acc),
    .re_i    (ctrl3_i.valid),
    .raddr_i (addr3_i),
    .rdata_o (rdata)
  );

  // take the previous beat's sum when it hit the same entry
  assign base  = (fwd_valid_q && (fwd_addr_q == addr4_q)) ? fwd_data_q : rdata;
  assign x_ext = SUM_W'(x_pipe_q[PIPE_DEPTH-1]);
  assign acc   = first4_q ? x_ext : (base + x_ext);
  assign sum_o = (relu4_q && acc[SUM_W-1]) ? '0 : $signed(acc);

endmodule

### src/csrr_addr.sv
// Position sequencer: channel/row/column counters, plane address modulo the
// memory depth, and destination vector index, pipelined over four stages.
// Depends on csrr_pkg.
module csrr_addr #(
  parameter int unsigned PLANE_VECTORS = csrr_pkg::PLANE_VECTORS_DEF,
  parameter int unsigned MAX_CHANNELS  = csrr_pkg::MAX_CHANNELS_DEF,
  localparam int unsigned AW           = $clog2(PLANE_VECTORS)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  csrr_pkg::csrr_cfg_t            cfg_i,
  input  logic                           accept_i,
  output csrr_pkg::csrr_ctrl_t           ctrl3_o,
  output logic [AW-1:0]                  addr3_o,
  output csrr_pkg::csrr_ctrl_t           ctrl4_o,
  output logic [csrr_pkg::DEST_W-1:0]    dest4_o
);
  import csrr_pkg::*;

  localparam int unsigned CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned PW   = GEOM_W + POS_W;
  localparam int unsigned MW   = LIN_W + RECIP_W;
  localparam int unsigned IKW  = IMG_W + KPI_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** LIN_W) / PLANE_VECTORS);
  localparam logic [LIN_W:0]     PV_L  = (LIN_W + 1)'(PLANE_VECTORS);

  logic [POS_W-1:0]      row_q, col_q;
  logic [CHW-1:0]        chan_q;
  logic [GEOM_W-1:0]     rows_c, cols_c;
  logic [CHAN_CMP_W-1:0] chan_ext, chans_c;
  logic [POS_W-1:0]      row, col;
  logic [CHW-1:0]        chan;
  logic                  last_chan, last_row, last_col;
  logic [PW-1:0]         prod0;
  logic [IKW-1:0]        ik0;
  csrr_ctrl_t            ctrl0;

  csrr_ctrl_t            ctrl1_q, ctrl2_q, ctrl3_q, ctrl4_q;
  logic [PW-1:0]         prod1_q;
  logic [POS_W-1:0]      row1_q, col1_q, row2_q, col2_q, col3_q;
  logic [GEOM_W-1:0]     rows1_q, cols1_q, cols2_q;
  logic [IKW-1:0]        ik1_q;
  logic [KIDX_W-1:0]     kidx1_q;
  logic [LIN_W-1:0]      lin1, lin2_q, lin3_q;
  logic [MW-1:0]         linm1, linm2_q;
  logic [LIN_W-1:0]      ik_sum1;
  logic [DEST_W-1:0]     ikr1, ikr2_q;
  logic [RECIP_W-1:0]    q2;
  logic [LIN_W-1:0]      qp2, qp3_q;
  logic [DEST_W-1:0]     dsum2, dest2, dest3_q, dest4_q;
  logic [LIN_W:0]        rem3;

  always_comb begin
    if (cfg_i.row_count == '0) begin
      rows_c = GEOM_W'(1);
    end else if (cfg_i.row_count > GEOM_MAX) begin
      rows_c = GEOM_MAX;
    end else begin
      rows_c = cfg_i.row_count;
    end
    if (cfg_i.vector_columns == '0) begin
      cols_c = GEOM_W'(1);
    end else if (cfg_i.vector_columns > GEOM_MAX) begin
      cols_c = GEOM_MAX;
    end else begin
      cols_c = cfg_i.vector_columns;
    end
    chan_ext = CHAN_CMP_W'(cfg_i.channel_count);
    if (chan_ext == '0) begin
      chans_c = CHAN_CMP_W'(1);
    end else if (chan_ext > CHAN_CMP_W'(MAX_CHANNELS)) begin
      chans_c = CHAN_CMP_W'(MAX_CHANNELS);
    end else begin
      chans_c = chan_ext;
    end
  end

  assign row       = (GEOM_W'(row_q) < rows_c) ? row_q : '0;
  assign col       = (GEOM_W'(col_q) < cols_c) ? col_q : '0;
  assign chan      = (CHAN_CMP_W'(chan_q) < chans_c) ? chan_q : '0;
  assign last_chan = (CHAN_CMP_W'(chan) + CHAN_CMP_W'(1)) >= chans_c;
  assign last_row  = (GEOM_W'(row) + GEOM_W'(1)) >= rows_c;
  assign last_col  = (GEOM_W'(col) + GEOM_W'(1)) >= cols_c;
  assign prod0     = PW'(row) * PW'(cols_c);
  assign ik0       = IKW'(cfg_i.image_index) * IKW'(cfg_i.kernels_per_image);

  always_comb begin
    ctrl0.valid      = accept_i;
    ctrl0.first      = (chan == '0);
    ctrl0.emit       = last_chan;
    ctrl0.plane_done = last_row && last_col;
    ctrl0.relu       = cfg_i.relu_enable;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      chan_q <= '0;
    end else if (accept_i) begin
      if (last_col) begin
        col_q <= '0;
        if (last_row) begin
          row_q  <= '0;
          chan_q <= last_chan ? '0 : (chan + CHW'(1));
        end else begin
          row_q  <= row + POS_W'(1);
          chan_q <= chan;
        end
      end else begin
        col_q  <= col + POS_W'(1);
        row_q  <= row;
        chan_q <= chan;
      end
    end
  end

  // plane position modulo depth: reciprocal estimate, then one correction
  assign lin1    = LIN_W'(prod1_q) + LIN_W'(col1_q);
  assign linm1   = MW'(lin1) * MW'(RECIP);
  assign ik_sum1 = LIN_W'(ik1_q) + LIN_W'(kidx1_q);
  assign ikr1    = DEST_W'(ik_sum1) * DEST_W'(rows1_q);

  assign q2      = linm2_q[MW-1:LIN_W];
  assign qp2     = LIN_W'(q2) * LIN_W'(PLANE_VECTORS);
  assign dsum2   = ikr2_q + DEST_W'(row2_q);
  assign dest2   = dsum2 * DEST_W'(cols2_q);

  assign rem3    = (LIN_W + 1)'(lin3_q) - (LIN_W + 1)'(qp3_q);
  assign addr3_o = (rem3 >= PV_L) ? AW'(rem3 - PV_L) : AW'(rem3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      ctrl3_q <= '0;
      ctrl4_q <= '0;
    end else begin
      ctrl1_q <= ctrl0;
      ctrl2_q <= ctrl1_q;
      ctrl3_q <= ctrl2_q;
      ctrl4_q <= ctrl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= prod0;
    row1_q  <= row;
    col1_q  <= col;
    rows1_q <= rows_c;
    cols1_q <= cols_c;
    ik1_q   <= ik0;
    kidx1_q <= cfg_i.kernel_index;
    lin2_q  <= lin1;
    linm2_q <= linm1;
    ikr2_q  <= ikr1;
    row2_q  <= row1_q;
    col2_q  <= col1_q;
    cols2_q <= cols1_q;
    lin3_q  <= lin2_q;
    qp3_q   <= qp2;
    dest3_q <= dest2;
    col3_q  <= col2_q;
    dest4_q <= dest3_q + DEST_W'(col3_q);
  end

  assign ctrl3_o = ctrl3_q;
  assign ctrl4_o = ctrl4_q;
  assign dest4_o = dest4_q;

endmodule

### src/csrr_merge.sv
// Merge stage: packs lane sums and destination index into one beat, queues it
// in the output FIFO and grants input credits.
// Depends on csrr_pkg.
module csrr_merge #(
  parameter int unsigned LANES       = csrr_pkg::LANES_DEF,
  localparam int unsigned PAY_W      = LANES * csrr_pkg::SUM_W + csrr_pkg::DEST_W,
  localparam int unsigned OUT_DATA_W = ((PAY_W + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  csrr_pkg::csrr_ctrl_t               ctrl4_i,
  input  logic [csrr_pkg::DEST_W-1:0]        dest4_i,
  input  logic signed [csrr_pkg::SUM_W-1:0]  sums_i [LANES],
  input  logic                               accept_i,
  output logic                               in_ready_o,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [OUT_DATA_W-1:0]              m_tdata_o,
  output logic                               m_tlast_o
);
  import csrr_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [PAY_W:0]   fifo_q [FIFO_DEPTH];
  logic [PAY_W:0]   word;
  logic [PAY_W:0]   head;
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fcnt_q, pend_q;
  logic             push, pop, drop;

  always_comb begin
    word = '0;
    for (int k = 0; k < LANES; k++) begin
      word[k*SUM_W +: SUM_W] = sums_i[k];
    end
    word[LANES*SUM_W +: DEST_W] = dest4_i;
    word[PAY_W]                 = ctrl4_i.plane_done;
  end

  assign push = ctrl4_i.valid && ctrl4_i.emit;
  assign drop = ctrl4_i.valid && !ctrl4_i.emit;
  assign pop  = m_tvalid_o && m_tready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fcnt_q   <= '0;
      pend_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      fcnt_q <= fcnt_q + CNT_W'(push) - CNT_W'(pop);
      pend_q <= pend_q + CNT_W'(accept_i) - CNT_W'(drop) - CNT_W'(pop);
    end
  end

  // every beat in flight or queued holds a credit until it leaves
  assign in_ready_o = pend_q < CNT_W'(FIFO_DEPTH);
  assign head       = fifo_q[rd_ptr_q];
  assign m_tvalid_o = (fcnt_q != '0);
  assign m_tdata_o  = OUT_DATA_W'(head[PAY_W-1:0]);
  assign m_tlast_o  = head[PAY_W];

endmodule

### src/channel_sum_relu_reducer.sv
// Channel sum / ReLU reducer, top level. Depends on csrr_pkg, csrr_addr,
// csrr_lane, csrr_ram and csrr_merge.
// Path: 4-stage address pipeline, then a read-modify-write in the lane banks,
// then the output FIFO. Throughput: one beat per cycle; s_axis_tready drops
// once 8 beats sit in flight or in the output FIFO.
// Reset clears counters, FIFO pointers, valid bits and config registers to defaults; banks are not cleared.
module channel_sum_relu_reducer #(
  parameter int unsigned LANES         = csrr_pkg::LANES_DEF,
  parameter int unsigned PLANE_VECTORS = csrr_pkg::PLANE_VECTORS_DEF,
  parameter int unsigned MAX_CHANNELS  = csrr_pkg::MAX_CHANNELS_DEF,
  localparam int unsigned IN_DATA_W    = LANES * csrr_pkg::LANE_W,
  localparam int unsigned OUT_DATA_W   =
    ((LANES * csrr_pkg::SUM_W + csrr_pkg::DEST_W + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [csrr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [csrr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // lane0 .. laneN-1, 16 bits each, from the low bit up
  input  logic [IN_DATA_W-1:0]                s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // sum0 .. sumN-1 at 24 bits each, then dest_vector_index (28), zero pad
  output logic [OUT_DATA_W-1:0]               m_axis_tdata,
  output logic                                m_axis_tlast
);
  import csrr_pkg::*;

  localparam int unsigned AW = $clog2(PLANE_VECTORS);

  csrr_cfg_t               cfg_q;
  logic                    accept;
  csrr_ctrl_t              ctrl3, ctrl4;
  logic [AW-1:0]           addr3;
  logic [DEST_W-1:0]       dest4;
  logic signed [SUM_W-1:0] sums [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_count         <= GEOM_W'(1);
      cfg_q.vector_columns    <= GEOM_W'(1);
      cfg_q.channel_count     <= CHAN_REG_W'(1);
      cfg_q.relu_enable       <= 1'b0;
      cfg_q.kernels_per_image <= KPI_W'(1);
      cfg_q.image_index       <= '0;
      cfg_q.kernel_index      <= '0;
    end else if (cfg_we_i) begin
      unique case (csrr_reg_e'(cfg_idx_i))
        REG_ROW_COUNT:     cfg_q.row_count         <= cfg_wdata_i;
        REG_VECTOR_COLS:   cfg_q.vector_columns    <= cfg_wdata_i;
        REG_CHANNEL_COUNT: cfg_q.channel_count     <= cfg_wdata_i[CHAN_REG_W-1:0];
        REG_RELU_ENABLE:   cfg_q.relu_enable       <= cfg_wdata_i[0];
        REG_KERNELS:       cfg_q.kernels_per_image <= cfg_wdata_i;
        REG_IMAGE_INDEX:   cfg_q.image_index       <= cfg_wdata_i[IMG_W-1:0];
        REG_KERNEL_INDEX:  cfg_q.kernel_index      <= cfg_wdata_i[KIDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  csrr_addr #(
    .PLANE_VECTORS (PLANE_VECTORS),
    .MAX_CHANNELS  (MAX_CHANNELS)
  ) u_addr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .ctrl3_o  (ctrl3),
    .addr3_o  (addr3),
    .ctrl4_o  (ctrl4),
    .dest4_o  (dest4)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    csrr_lane #(
      .PLANE_VECTORS (PLANE_VECTORS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .x_i     ($signed(s_axis_tdata[k*LANE_W +: LANE_W])),
      .ctrl3_i (ctrl3),
      .addr3_i (addr3),
      .sum_o   (sums[k])
    );
  end

  csrr_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl4_i    (ctrl4),
    .dest4_i    (dest4),
    .sums_i     (sums),
    .accept_i   (accept),
    .in_ready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule
